/* rtl/core/bfa_pkg.sv */
`default_nettype none

package bfa_pkg;

  localparam int STORE_WORDS = 64;
  localparam int WORD_BITS   = 64;
  localparam int FIELD_BITS  = 64;
  localparam int IDX_W       = 12;
  localparam int LEN_W       = 7;

  localparam int ADDR_W = $clog2(STORE_WORDS);
  localparam int OFF_W  = $clog2(WORD_BITS);

  // highest word a field can touch, plus one step past it
  localparam int MAX_WORD   = ((1 << IDX_W) + FIELD_BITS - 2) / WORD_BITS;
  localparam int WADR_W_A   = $clog2(MAX_WORD + 2);
  localparam int WADR_W     = (WADR_W_A > ADDR_W) ? WADR_W_A : ADDR_W + 1;

  // field position of word bit 0 spans -(WORD_BITS-1) .. FIELD_BITS+WORD_BITS
  localparam int SH_W = $clog2(FIELD_BITS + WORD_BITS) + 2;

  // exact floor division of an index by WORD_BITS by reciprocal multiply
  localparam int DIV_S   = IDX_W + $clog2(WORD_BITS);
  localparam int DIV_M   = ((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;
  localparam int DIV_M_W = IDX_W + 2;
  localparam int PROD_W  = IDX_W + DIV_M_W;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RUN   = 3'b100
  } state_t;

  typedef struct packed {
    logic signed [SH_W-1:0]  fshift;
    logic [FIELD_BITS-1:0]   len_mask;
    logic [FIELD_BITS-1:0]   value;
  } merge_req_t;

  function automatic logic [WADR_W-1:0] word_of(input logic [IDX_W-1:0] x);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(x) * PROD_W'(DIV_M);
    return WADR_W'(prod >> DIV_S);
  endfunction

  function automatic logic [OFF_W-1:0] off_of(input logic [IDX_W-1:0] x,
                                              input logic [WADR_W-1:0] q);
    logic [IDX_W-1:0] base;
    base = IDX_W'(IDX_W'(q) * IDX_W'(WORD_BITS));
    return OFF_W'(x - base);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bfa_ram.sv */
`default_nettype none

module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bfa_merge.sv */
`default_nettype none

module bfa_merge (
  input  bfa_pkg::merge_req_t                req,
  input  logic [bfa_pkg::WORD_BITS-1:0]      rdata,
  output logic [bfa_pkg::FIELD_BITS-1:0]     part,
  output logic [bfa_pkg::WORD_BITS-1:0]      wdata
);

  logic                              neg;
  logic [bfa_pkg::SH_W-1:0]          mag;
  logic [bfa_pkg::FIELD_BITS-1:0]    wext;
  logic [bfa_pkg::FIELD_BITS-1:0]    wmask_f;
  logic [bfa_pkg::FIELD_BITS-1:0]    vword_f;
  logic [bfa_pkg::WORD_BITS-1:0]     wmask;
  logic [bfa_pkg::WORD_BITS-1:0]     vword;

  // field bit i sits at word bit i - fshift
  always_comb begin
    neg  = req.fshift < 0;
    mag  = neg ? $unsigned(-req.fshift) : $unsigned(req.fshift);
    wext = bfa_pkg::FIELD_BITS'(rdata);
    if (neg) begin
      part    = (wext >> mag) & req.len_mask;
      wmask_f = req.len_mask << mag;
      vword_f = req.value << mag;
    end else begin
      part    = (wext << mag) & req.len_mask;
      wmask_f = req.len_mask >> mag;
      vword_f = req.value >> mag;
    end
    wmask = wmask_f[bfa_pkg::WORD_BITS-1:0];
    vword = vword_f[bfa_pkg::WORD_BITS-1:0];
    wdata = (rdata & ~wmask) | (vword & wmask);
  end

endmodule

`default_nettype wire

/* rtl/core/bit_vector_field_access_unit.sv */
`default_nettype none

// channel   signals                                           handshake
// item in   op, bit_index, field_length, field_value          start & !busy
// result    field_data                                        done, one cycle
//
// A field covering n words (1 or 2 at 64-bit words) is handled word by
// word; busy drops in the done cycle, so a new item can be accepted then.
// The pace is set by the read-modify-write of each word through
// the store RAM (one read port, one write port, registered read).
// After reset a clearing pass writes zero to all STORE_WORDS words, one a
// cycle, with busy high. The receiver cannot stall: done is a strobe.

module bit_vector_field_access_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             op,
  input  logic [bfa_pkg::IDX_W-1:0]        bit_index,
  input  logic [bfa_pkg::LEN_W-1:0]        field_length,
  input  logic [bfa_pkg::FIELD_BITS-1:0]   field_value,
  output logic                             done,
  output logic [bfa_pkg::FIELD_BITS-1:0]   field_data
);

  bfa_pkg::state_t state;

  logic [bfa_pkg::ADDR_W-1:0]           clr_addr;
  logic [bfa_pkg::WADR_W-1:0]           rd_word;
  logic signed [bfa_pkg::SH_W-1:0]      rd_shift;
  logic                                 rd_more;
  logic                                 wr_act;
  logic [bfa_pkg::WADR_W-1:0]           wr_word;
  logic signed [bfa_pkg::SH_W-1:0]      wr_shift;
  logic                                 op_r;
  logic [bfa_pkg::LEN_W-1:0]            len_r;
  logic [bfa_pkg::FIELD_BITS-1:0]       mask_r;
  logic [bfa_pkg::FIELD_BITS-1:0]       value_r;
  logic [bfa_pkg::FIELD_BITS-1:0]       acc;
  logic [bfa_pkg::FIELD_BITS-1:0]       acc_next;

  logic                                 accept;
  logic [bfa_pkg::LEN_W-1:0]            len_sat;
  logic [bfa_pkg::FIELD_BITS-1:0]       mask_in;
  logic [bfa_pkg::WADR_W-1:0]           q0;
  logic [bfa_pkg::OFF_W-1:0]            off0;
  logic signed [bfa_pkg::SH_W-1:0]      step;
  logic signed [bfa_pkg::SH_W-1:0]      shift0;
  logic signed [bfa_pkg::SH_W-1:0]      shift0_adv;
  logic signed [bfa_pkg::SH_W-1:0]      rd_shift_next;
  logic signed [bfa_pkg::SH_W-1:0]      len_in_s;
  logic signed [bfa_pkg::SH_W-1:0]      len_s;
  logic                                 more0;
  logic                                 more_n;
  logic                                 rd_issue;
  logic                                 wr_inrange;
  logic                                 last;

  logic                                 ram_we;
  logic [bfa_pkg::ADDR_W-1:0]           ram_waddr;
  logic [bfa_pkg::WORD_BITS-1:0]        ram_wdata;
  logic                                 ram_re;
  logic [bfa_pkg::ADDR_W-1:0]           ram_raddr;
  logic [bfa_pkg::WORD_BITS-1:0]        ram_rdata;

  bfa_pkg::merge_req_t                  mreq;
  logic [bfa_pkg::FIELD_BITS-1:0]       part;
  logic [bfa_pkg::WORD_BITS-1:0]        merged;

  assign busy   = (state != bfa_pkg::ST_IDLE);
  assign accept = start && (state == bfa_pkg::ST_IDLE);

  always_comb begin
    if (field_length > bfa_pkg::LEN_W'(bfa_pkg::FIELD_BITS)) begin
      len_sat = bfa_pkg::LEN_W'(bfa_pkg::FIELD_BITS);
    end else begin
      len_sat = field_length;
    end
    if (len_sat == bfa_pkg::LEN_W'(bfa_pkg::FIELD_BITS)) begin
      mask_in = '1;
    end else begin
      mask_in = (bfa_pkg::FIELD_BITS'(1) << len_sat) - bfa_pkg::FIELD_BITS'(1);
    end
  end

  assign q0            = bfa_pkg::word_of(bit_index);
  assign off0          = bfa_pkg::off_of(bit_index, q0);
  assign step          = $signed(bfa_pkg::SH_W'(bfa_pkg::WORD_BITS));
  assign shift0        = -$signed(bfa_pkg::SH_W'(off0));
  assign shift0_adv    = shift0 + step;
  assign len_in_s      = $signed(bfa_pkg::SH_W'(len_sat));
  assign more0         = shift0_adv < len_in_s;
  assign rd_shift_next = rd_shift + step;
  assign len_s         = $signed(bfa_pkg::SH_W'(len_r));
  assign more_n        = rd_shift_next < len_s;
  assign rd_issue      = (state == bfa_pkg::ST_RUN) && rd_more;
  assign wr_inrange    = wr_word < bfa_pkg::WADR_W'(bfa_pkg::STORE_WORDS);
  assign last          = (state == bfa_pkg::ST_RUN) && wr_act && !rd_more;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = rd_word[bfa_pkg::ADDR_W-1:0];
    if (accept) begin
      ram_re    = q0 < bfa_pkg::WADR_W'(bfa_pkg::STORE_WORDS);
      ram_raddr = q0[bfa_pkg::ADDR_W-1:0];
    end else if (rd_issue) begin
      ram_re    = rd_word < bfa_pkg::WADR_W'(bfa_pkg::STORE_WORDS);
    end
  end

  always_comb begin
    if (state == bfa_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == bfa_pkg::ST_RUN) && wr_act && wr_inrange &&
                  (op_r == bfa_pkg::OP_SET);
      ram_waddr = wr_word[bfa_pkg::ADDR_W-1:0];
      ram_wdata = merged;
    end
  end

  assign mreq.fshift   = wr_shift;
  assign mreq.len_mask = mask_r;
  assign mreq.value    = value_r;
  assign acc_next      = acc | (wr_inrange ? part : '0);

  bfa_ram #(
    .WIDTH(bfa_pkg::WORD_BITS),
    .DEPTH(bfa_pkg::STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bfa_merge u_merge (
    .req   (mreq),
    .rdata (ram_rdata),
    .part  (part),
    .wdata (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bfa_pkg::ST_CLEAR;
      clr_addr <= '0;
      rd_more  <= 1'b0;
      wr_act   <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        bfa_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + bfa_pkg::ADDR_W'(1);
          if (clr_addr == bfa_pkg::ADDR_W'(bfa_pkg::STORE_WORDS - 1)) begin
            state <= bfa_pkg::ST_IDLE;
          end
        end
        bfa_pkg::ST_IDLE: begin
          if (start) begin
            state   <= bfa_pkg::ST_RUN;
            wr_act  <= 1'b1;
            rd_more <= more0;
          end
        end
        bfa_pkg::ST_RUN: begin
          wr_act <= rd_more;
          if (rd_more) begin
            rd_more <= more_n;
          end
          if (last) begin
            done  <= 1'b1;
            state <= bfa_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= bfa_pkg::ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op;
      len_r    <= len_sat;
      mask_r   <= mask_in;
      value_r  <= field_value;
      wr_word  <= q0;
      wr_shift <= shift0;
      rd_word  <= q0 + bfa_pkg::WADR_W'(1);
      rd_shift <= shift0_adv;
      acc      <= '0;
    end else if (state == bfa_pkg::ST_RUN) begin
      if (rd_more) begin
        wr_word  <= rd_word;
        wr_shift <= rd_shift;
        rd_word  <= rd_word + bfa_pkg::WADR_W'(1);
        rd_shift <= rd_shift_next;
      end
      if (wr_act) begin
        acc <= acc_next;
      end
      if (last) begin
        field_data <= acc_next;
      end
    end
  end

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == bfa_pkg::ST_RUN))
    else $error("result strobe without a finished item");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("store read and write hit the same word");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not hold busy");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == bfa_pkg::ST_IDLE) |-> !ram_we)
    else $error("store written while idle");

endmodule

`default_nettype wire
